[rtl/mftr_pkg.sv]
`default_nettype none

package mftr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  // scale (7) + root (SQRT_STEPS) + divide setup (1) + divide + output (1)
  localparam int NORM_LAT   = 9 + SQRT_STEPS + DIV_STEPS;

  localparam logic [1:0] REG_DIPOLE   = 2'd0;
  localparam logic [1:0] REG_POL_IN   = 2'd1;
  localparam logic [1:0] REG_POL_OUT  = 2'd2;
  localparam logic [1:0] REG_POL_BIS  = 2'd3;

  // data that rides alongside a vector through the normalizer
  typedef struct packed {
    logic                             ok;
    logic [2:0][DATA_WIDTH-1:0]       v;
  } side_t;

  // shift right by 30, half away from zero
  function automatic logic signed [69:0] rnd30(input logic signed [69:0] x);
    logic [69:0] m;
    logic [69:0] q;
    m = x[69] ? 70'(-x) : 70'(x);
    q = (m + 70'd536870912) >> 30;
    rnd30 = x[69] ? 70'(-$signed(q)) : $signed(q);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [69:0] x);
    logic signed [69:0] mx;
    logic signed [69:0] mn;
    mx = 70'sd2147483647;
    mn = -70'sd2147483648;
    if (x > mx) begin
      sat_dw = 32'sh7fffffff;
    end else if (x < mn) begin
      sat_dw = 32'sh80000000;
    end else begin
      sat_dw = x[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/molecular_frame_tensor_rotation_unit.sv]
`default_nettype none

// Molecular-frame rotation for water: each request carries the two O-H bond
// vectors (signed Q15.16) and returns the lab-frame dipole and the six
// elements of the symmetric polarizability tensor (Q15.16, saturated), plus a
// degenerate flag that is set, with all values zero, when the bisector or
// the out-of-plane cross product has zero length. The pipeline takes one
// request per cycle while it is not stalled; the two vector normalizers
// (root and divide, one bit per stage each) make up most of its depth. A
// stall on the output freezes the whole pipeline and holds off the input.
// Registers are to be written through the APB port only while no request is
// in flight; the user must keep to this, the block itself does not enforce it.
module molecular_frame_tensor_rotation_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  bond1_x,
  input  logic signed [31:0]  bond1_y,
  input  logic signed [31:0]  bond1_z,
  input  logic signed [31:0]  bond2_x,
  input  logic signed [31:0]  bond2_y,
  input  logic signed [31:0]  bond2_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  dipole_x,
  output logic signed [31:0]  dipole_y,
  output logic signed [31:0]  dipole_z,
  output logic signed [31:0]  tensor_xx,
  output logic signed [31:0]  tensor_yx,
  output logic signed [31:0]  tensor_yy,
  output logic signed [31:0]  tensor_zx,
  output logic signed [31:0]  tensor_zy,
  output logic signed [31:0]  tensor_zz,
  output logic                degenerate
);

  localparam int RI [6] = '{0, 1, 1, 2, 2, 2};
  localparam int CI [6] = '{0, 0, 1, 0, 1, 2};

  logic adv;
  logic signed [31:0] dipole_mag, pol_in, pol_out, pol_bis;

  assign pready   = 1'b1;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dipole_mag <= '0;
      pol_in     <= '0;
      pol_out    <= '0;
      pol_bis    <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        mftr_pkg::REG_DIPOLE:  dipole_mag <= pwdata;
        mftr_pkg::REG_POL_IN:  pol_in     <= pwdata;
        mftr_pkg::REG_POL_OUT: pol_out    <= pwdata;
        mftr_pkg::REG_POL_BIS: pol_bis    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mftr_pkg::REG_DIPOLE:  prdata = dipole_mag;
      mftr_pkg::REG_POL_IN:  prdata = pol_in;
      mftr_pkg::REG_POL_OUT: prdata = pol_out;
      mftr_pkg::REG_POL_BIS: prdata = pol_bis;
      default:               prdata = '0;
    endcase
  end

  // ---------------- input stage: bisector sum
  logic               t0_v;
  logic signed [31:0] t0_b1 [3];
  logic signed [63:0] t0_s  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_b1[0] <= bond1_x;
      t0_b1[1] <= bond1_y;
      t0_b1[2] <= bond1_z;
      t0_s[0]  <= 64'(bond1_x) + 64'(bond2_x);
      t0_s[1]  <= 64'(bond1_y) + 64'(bond2_y);
      t0_s[2]  <= 64'(bond1_z) + 64'(bond2_z);
    end
  end

  // ---------------- bisector normalizer
  mftr_pkg::side_t    n1_side_in, n1_side;
  logic               n1_v, n1_ok;
  logic signed [31:0] n1_u0, n1_u1, n1_u2;

  always_comb begin
    n1_side_in.ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      n1_side_in.v[i] = t0_b1[i];
    end
  end

  mftr_norm u_norm_bis (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (t0_v),
    .vec0     (t0_s[0]),
    .vec1     (t0_s[1]),
    .vec2     (t0_s[2]),
    .side_in  (n1_side_in),
    .out_valid(n1_v),
    .out_ok   (n1_ok),
    .u0       (n1_u0),
    .u1       (n1_u1),
    .u2       (n1_u2),
    .side_out (n1_side)
  );

  // ---------------- cross product e3 x bond1
  logic               t1_v, t1_ok;
  logic signed [31:0] t1_e3 [3];
  logic signed [63:0] t1_p  [6];
  logic               t2_v, t2_ok;
  logic signed [31:0] t2_e3 [3];
  logic signed [63:0] t2_c  [3];
  logic signed [31:0] b1x, b1y, b1z;

  assign b1x = $signed(n1_side.v[0]);
  assign b1y = $signed(n1_side.v[1]);
  assign b1z = $signed(n1_side.v[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_ok    <= n1_ok && n1_side.ok;
      t1_e3[0] <= n1_u0;
      t1_e3[1] <= n1_u1;
      t1_e3[2] <= n1_u2;
      t1_p[0]  <= n1_u1 * b1z;
      t1_p[1]  <= n1_u2 * b1y;
      t1_p[2]  <= n1_u2 * b1x;
      t1_p[3]  <= n1_u0 * b1z;
      t1_p[4]  <= n1_u0 * b1y;
      t1_p[5]  <= n1_u1 * b1x;
      t2_ok    <= t1_ok;
      t2_e3    <= t1_e3;
      t2_c[0]  <= t1_p[0] - t1_p[1];
      t2_c[1]  <= t1_p[2] - t1_p[3];
      t2_c[2]  <= t1_p[4] - t1_p[5];
    end
  end

  // ---------------- out-of-plane normalizer
  mftr_pkg::side_t    n2_side_in, n2_side;
  logic               n2_v, n2_ok;
  logic signed [31:0] n2_u0, n2_u1, n2_u2;

  always_comb begin
    n2_side_in.ok = t2_ok;
    for (int i = 0; i < 3; i++) begin
      n2_side_in.v[i] = t2_e3[i];
    end
  end

  mftr_norm u_norm_out (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (t2_v),
    .vec0     (t2_c[0]),
    .vec1     (t2_c[1]),
    .vec2     (t2_c[2]),
    .side_in  (n2_side_in),
    .out_valid(n2_v),
    .out_ok   (n2_ok),
    .u0       (n2_u0),
    .u1       (n2_u1),
    .u2       (n2_u2),
    .side_out (n2_side)
  );

  // ---------------- in-plane axis and tensor
  logic               p1_v, p2_v, p3_v, p4_v, p5_v, p6_v, p7_v;
  logic               p1_ok, p2_ok, p3_ok, p4_ok, p5_ok, p6_ok, p7_ok;
  logic signed [31:0] p1_e2 [3], p1_e3 [3], p2_e2 [3], p2_e3 [3];
  logic signed [31:0] p3_e2 [3], p3_e3 [3];
  logic signed [63:0] p1_m  [6];
  logic signed [63:0] p2_d  [3];
  logic signed [32:0] p3_e1 [3];
  logic signed [65:0] p4_pa [6];
  logic signed [63:0] p4_pb [6], p4_pc [6], p4_dp [3];
  logic signed [33:0] p5_qa [6], p5_qb [6], p5_qc [6], p5_dq [3];
  logic signed [65:0] p6_ma [6], p6_mb [6], p6_mc [6];
  logic signed [33:0] p6_dq [3], p7_dq [3];
  logic signed [35:0] p7_ra [6], p7_rb [6], p7_rc [6];
  logic signed [37:0] tsum  [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ok    <= n2_ok && n2_side.ok;
      p1_e2[0] <= n2_u0;
      p1_e2[1] <= n2_u1;
      p1_e2[2] <= n2_u2;
      for (int i = 0; i < 3; i++) begin
        p1_e3[i] <= $signed(n2_side.v[i]);
      end
      p1_m[0] <= n2_u1 * $signed(n2_side.v[2]);
      p1_m[1] <= n2_u2 * $signed(n2_side.v[1]);
      p1_m[2] <= n2_u2 * $signed(n2_side.v[0]);
      p1_m[3] <= n2_u0 * $signed(n2_side.v[2]);
      p1_m[4] <= n2_u0 * $signed(n2_side.v[1]);
      p1_m[5] <= n2_u1 * $signed(n2_side.v[0]);

      p2_ok   <= p1_ok;
      p2_e2   <= p1_e2;
      p2_e3   <= p1_e3;
      p2_d[0] <= p1_m[0] - p1_m[1];
      p2_d[1] <= p1_m[2] - p1_m[3];
      p2_d[2] <= p1_m[4] - p1_m[5];

      p3_ok <= p2_ok;
      p3_e2 <= p2_e2;
      p3_e3 <= p2_e3;
      for (int i = 0; i < 3; i++) begin
        p3_e1[i] <= 33'(mftr_pkg::rnd30(70'(p2_d[i])));
      end

      p4_ok <= p3_ok;
      for (int k = 0; k < 6; k++) begin
        p4_pa[k] <= p3_e1[RI[k]] * p3_e1[CI[k]];
        p4_pb[k] <= p3_e2[RI[k]] * p3_e2[CI[k]];
        p4_pc[k] <= p3_e3[RI[k]] * p3_e3[CI[k]];
      end
      for (int i = 0; i < 3; i++) begin
        p4_dp[i] <= dipole_mag * p3_e3[i];
      end

      p5_ok <= p4_ok;
      for (int k = 0; k < 6; k++) begin
        p5_qa[k] <= 34'(mftr_pkg::rnd30(70'(p4_pa[k])));
        p5_qb[k] <= 34'(mftr_pkg::rnd30(70'(p4_pb[k])));
        p5_qc[k] <= 34'(mftr_pkg::rnd30(70'(p4_pc[k])));
      end
      for (int i = 0; i < 3; i++) begin
        p5_dq[i] <= 34'(mftr_pkg::rnd30(70'(p4_dp[i])));
      end

      p6_ok <= p5_ok;
      p6_dq <= p5_dq;
      for (int k = 0; k < 6; k++) begin
        p6_ma[k] <= pol_in  * p5_qa[k];
        p6_mb[k] <= pol_out * p5_qb[k];
        p6_mc[k] <= pol_bis * p5_qc[k];
      end

      p7_ok <= p6_ok;
      p7_dq <= p6_dq;
      for (int k = 0; k < 6; k++) begin
        p7_ra[k] <= 36'(mftr_pkg::rnd30(70'(p6_ma[k])));
        p7_rb[k] <= 36'(mftr_pkg::rnd30(70'(p6_mb[k])));
        p7_rc[k] <= 36'(mftr_pkg::rnd30(70'(p6_mc[k])));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tsum[k] = 38'(p7_ra[k]) + 38'(p7_rb[k]) + 38'(p7_rc[k]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      dipole_x   <= p7_ok ? mftr_pkg::sat_dw(70'(p7_dq[0])) : '0;
      dipole_y   <= p7_ok ? mftr_pkg::sat_dw(70'(p7_dq[1])) : '0;
      dipole_z   <= p7_ok ? mftr_pkg::sat_dw(70'(p7_dq[2])) : '0;
      tensor_xx  <= p7_ok ? mftr_pkg::sat_dw(70'(tsum[0])) : '0;
      tensor_yx  <= p7_ok ? mftr_pkg::sat_dw(70'(tsum[1])) : '0;
      tensor_yy  <= p7_ok ? mftr_pkg::sat_dw(70'(tsum[2])) : '0;
      tensor_zx  <= p7_ok ? mftr_pkg::sat_dw(70'(tsum[3])) : '0;
      tensor_zy  <= p7_ok ? mftr_pkg::sat_dw(70'(tsum[4])) : '0;
      tensor_zz  <= p7_ok ? mftr_pkg::sat_dw(70'(tsum[5])) : '0;
      degenerate <= !p7_ok;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v      <= 1'b0;
      t1_v      <= 1'b0;
      t2_v      <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      p4_v      <= 1'b0;
      p5_v      <= 1'b0;
      p6_v      <= 1'b0;
      p7_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      t0_v      <= in_valid;
      t1_v      <= n1_v;
      t2_v      <= t1_v;
      p1_v      <= n2_v;
      p2_v      <= p1_v;
      p3_v      <= p2_v;
      p4_v      <= p3_v;
      p5_v      <= p4_v;
      p6_v      <= p5_v;
      p7_v      <= p6_v;
      out_valid <= p7_v;
    end
  end

endmodule

`default_nettype wire

[rtl/mftr_norm.sv]
`default_nettype none

// Pipelined vector normalizer: scale to [2^29, 2^30), root of the sum of
// squares one bit per stage, then one quotient bit per stage for each lane.
module mftr_norm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic signed [63:0]     vec0,
  input  logic signed [63:0]     vec1,
  input  logic signed [63:0]     vec2,
  input  mftr_pkg::side_t        side_in,
  output logic                   out_valid,
  output logic                   out_ok,
  output logic signed [31:0]     u0,
  output logic signed [31:0]     u1,
  output logic signed [31:0]     u2,
  output mftr_pkg::side_t        side_out
);

  localparam int SQ = mftr_pkg::SQRT_STEPS;
  localparam int DV = mftr_pkg::DIV_STEPS;
  localparam int NL = mftr_pkg::NORM_LAT;

  typedef struct packed {
    logic                  ok;
    logic [2:0]            neg;
    logic [2:0][29:0]      a;
    mftr_pkg::side_t       side;
  } nc_t;

  logic [NL-1:0] vld;

  logic [63:0]           s1_mag [3];
  logic [2:0]            s1_neg;
  mftr_pkg::side_t       s1_side;

  logic [63:0]           s2_mag [3];
  logic [63:0]           s2_max;
  logic [2:0]            s2_neg;
  mftr_pkg::side_t       s2_side;
  logic [63:0]           max_c;

  logic [63:0]           s3_mag [3];
  logic [3:0]            s3_nz;
  logic [3:0]            s3_pos [4];
  logic [2:0]            s3_neg;
  mftr_pkg::side_t       s3_side;
  logic [3:0]            nz_c;
  logic [3:0]            pos_c [4];

  logic [63:0]           s4_mag [3];
  logic                  s4_rsh;
  logic [5:0]            s4_amt;
  logic                  s4_ok;
  logic [2:0]            s4_neg;
  mftr_pkg::side_t       s4_side;
  logic [5:0]            lead_c;
  logic                  rsh_c;
  logic [5:0]            amt_c;

  nc_t                   s5_c;
  nc_t                   s6_c;
  logic [59:0]           s6_sq [3];

  logic [63:0]           sn [0:SQ];
  logic [63:0]           sr [0:SQ];
  nc_t                   sc [0:SQ];

  logic [63:0]           dr [0:DV][0:2];
  logic [31:0]           dq [0:DV][0:2];
  logic [31:0]           dd [0:DV];
  nc_t                   dc [0:DV];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NL-2:0], in_valid};
    end
  end

  assign out_valid = vld[NL-1];

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag[0] <= vec0[63] ? 64'(-vec0) : 64'(vec0);
      s1_mag[1] <= vec1[63] ? 64'(-vec1) : 64'(vec1);
      s1_mag[2] <= vec2[63] ? 64'(-vec2) : 64'(vec2);
      s1_neg    <= {vec2[63], vec1[63], vec0[63]};
      s1_side   <= side_in;
    end
  end

  // stage 2: largest magnitude
  always_comb begin
    max_c = s1_mag[0];
    if (s1_mag[1] > max_c) begin
      max_c = s1_mag[1];
    end
    if (s1_mag[2] > max_c) begin
      max_c = s1_mag[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag  <= s1_mag;
      s2_max  <= max_c;
      s2_neg  <= s1_neg;
      s2_side <= s1_side;
    end
  end

  // stage 3: leading one within each 16-bit chunk
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      nz_c[c]  = |s2_max[16*c +: 16];
      pos_c[c] = '0;
      for (int i = 0; i < 16; i++) begin
        if (s2_max[16*c + i]) begin
          pos_c[c] = 4'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mag  <= s2_mag;
      s3_nz   <= nz_c;
      s3_pos  <= pos_c;
      s3_neg  <= s2_neg;
      s3_side <= s2_side;
    end
  end

  // stage 4: shift amount that puts the leading one at bit 29
  always_comb begin
    lead_c = '0;
    for (int c = 0; c < 4; c++) begin
      if (s3_nz[c]) begin
        lead_c = {2'(c), s3_pos[c]};
      end
    end
    rsh_c = lead_c > 6'd29;
    amt_c = rsh_c ? 6'(lead_c - 6'd29) : 6'(6'd29 - lead_c);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mag  <= s3_mag;
      s4_rsh  <= rsh_c;
      s4_amt  <= amt_c;
      s4_ok   <= |s3_nz;
      s4_neg  <= s3_neg;
      s4_side <= s3_side;
    end
  end

  // stage 5: scale
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_c.a[i] <= s4_rsh ? 30'(s4_mag[i] >> s4_amt) : 30'(s4_mag[i] << s4_amt);
      end
      s5_c.ok   <= s4_ok;
      s5_c.neg  <= s4_neg;
      s5_c.side <= s4_side;
    end
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s6_sq[i] <= 60'(s5_c.a[i]) * 60'(s5_c.a[i]);
      end
      s6_c <= s5_c;
    end
  end

  // stage 7: sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      sn[0] <= 64'(s6_sq[0]) + 64'(s6_sq[1]) + 64'(s6_sq[2]);
      sr[0] <= '0;
      sc[0] <= s6_c;
    end
  end

  // integer root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = sr[k] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sn[k] >= trial) begin
          sn[k+1] <= sn[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sn[k+1] <= sn[k];
          sr[k+1] <= sr[k] >> 1;
        end
        sc[k+1] <= sc[k];
      end
    end
  end

  // divide setup: a * 2^30 + r/2
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dr[0][i] <= (64'(sc[SQ].a[i]) << 30) + (sr[SQ] >> 1);
        dq[0][i] <= '0;
      end
      dd[0] <= sr[SQ][31:0];
      dc[0] <= sc[SQ];
    end
  end

  for (genvar j = 0; j < DV; j++) begin : g_div
    localparam int K = DV - 1 - j;
    logic [63:0] dsh;
    assign dsh = 64'(dd[j]) << K;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (dr[j][i] >= dsh) begin
            dr[j+1][i] <= dr[j][i] - dsh;
            dq[j+1][i] <= {dq[j][i][30:0], 1'b1};
          end else begin
            dr[j+1][i] <= dr[j][i];
            dq[j+1][i] <= {dq[j][i][30:0], 1'b0};
          end
        end
        dd[j+1] <= dd[j];
        dc[j+1] <= dc[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u0       <= dc[DV].neg[0] ? -$signed(dq[DV][0]) : $signed(dq[DV][0]);
      u1       <= dc[DV].neg[1] ? -$signed(dq[DV][1]) : $signed(dq[DV][1]);
      u2       <= dc[DV].neg[2] ? -$signed(dq[DV][2]) : $signed(dq[DV][2]);
      out_ok   <= dc[DV].ok;
      side_out <= dc[DV].side;
    end
  end

endmodule

`default_nettype wire
